FILE: sv/enfa_pkg.sv
// Shared types and constants for the lambda-NFA word acceptor.
// Used by the channel interfaces and by the front, queue, back and top modules; no dependencies.
`default_nettype none
package enfa_pkg;

  // Automaton geometry
  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 16;
  localparam int STATE_W     = $clog2(NUM_STATES);
  localparam int SYM_W       = $clog2(NUM_SYMBOLS);
  localparam int SET_W       = NUM_STATES;
  localparam int CHAR_W      = 8;
  localparam int MV_DEPTH    = NUM_STATES * NUM_SYMBOLS;
  localparam int MV_ADDR_W   = $clog2(MV_DEPTH);

  localparam logic [SET_W-1:0] STATE_MASK = {SET_W{1'b1}};

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SET_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK  = 1'b1;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_MOVE_ROW   = 2'd0,
    FUNC_LAMBDA_ROW = 2'd1,
    FUNC_ALPHA      = 2'd2,
    FUNC_FEED       = 2'd3
  } func_t;

  // Configuration register contents
  typedef struct packed {
    logic [STATE_W-1:0] start_state;
    logic [SET_W-1:0]   accept_mask;
  } cfg_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    func_t              func;
    logic [STATE_W-1:0] src;
    logic [SYM_W-1:0]   sym;
    logic               found;
    logic [SET_W-1:0]   targets;
    logic               last;
  } qent_t;

  // Back status seen by the top level
  typedef struct packed {
    logic busy;
  } bk_stat_t;

endpackage
`default_nettype wire

FILE: sv/enfa_ifs.sv
// Valid/ready channel interfaces for item input and result output.
// Depends on enfa_pkg for field widths.
`default_nettype none
interface enfa_in_if;
  import enfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [STATE_W-1:0]  source_state;
  logic [SYM_W-1:0]    symbol_index;
  logic [CHAR_W-1:0]   character;
  logic [SET_W-1:0]    target_set;
  logic                last_char;

  modport source (
    output valid, func, source_state, symbol_index, character, target_set, last_char,
    input  ready
  );
  modport sink (
    input  valid, func, source_state, symbol_index, character, target_set, last_char,
    output ready
  );
endinterface

interface enfa_out_if;
  import enfa_pkg::*;

  logic             valid;
  logic             ready;
  logic             accepted;
  logic [SET_W-1:0] final_set;

  modport source (output valid, accepted, final_set, input ready);
  modport sink (input valid, accepted, final_set, output ready);
endinterface
`default_nettype wire

FILE: sv/enfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module enfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/enfa_front.sv
// Front end: accepts items, applies alphabet writes and maps characters to symbols.
// Depends on enfa_pkg and enfa_in_if; pushes classified items into enfa_queue.
`default_nettype none
module enfa_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  enfa_in_if.sink             in_ch,
  output logic                q_push,
  output enfa_pkg::qent_t     q_entry,
  input  wire logic           q_full
);
  import enfa_pkg::*;

  logic [NUM_SYMBOLS-1:0][CHAR_W-1:0] alpha_chr_r;
  logic [NUM_SYMBOLS-1:0]             alpha_vld_r;
  logic [NUM_SYMBOLS-1:0]             hit;
  logic [SYM_W-1:0]                   hit_idx;
  logic                               accept;
  func_t                              func;

  assign func        = func_t'(in_ch.func);
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Compare the character against every defined entry, lowest index wins
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < NUM_SYMBOLS; k++) begin
      hit[k] = alpha_vld_r[k] && (alpha_chr_r[k] == in_ch.character);
    end
    for (int k = NUM_SYMBOLS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_idx = SYM_W'(k);
      end
    end
  end

  // Build the queue entry; alphabet writes stay here
  always_comb begin
    q_push          = accept && (func != FUNC_ALPHA);
    q_entry.func    = func;
    q_entry.src     = in_ch.source_state;
    q_entry.sym     = (func == FUNC_FEED) ? hit_idx : in_ch.symbol_index;
    q_entry.found   = |hit;
    q_entry.targets = in_ch.target_set & STATE_MASK;
    q_entry.last    = in_ch.last_char;
  end

  // Alphabet valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_vld_r <= '0;
    end else if (accept && (func == FUNC_ALPHA)) begin
      alpha_vld_r[in_ch.symbol_index] <= 1'b1;
    end
  end

  // Alphabet characters
  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_ALPHA)) begin
      alpha_chr_r[in_ch.symbol_index] <= in_ch.character;
    end
  end

endmodule
`default_nettype wire

FILE: sv/enfa_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on enfa_pkg.
`default_nettype none
module enfa_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire enfa_pkg::qent_t push_data,
  output logic                full,
  input  wire logic           pop,
  output enfa_pkg::qent_t     pop_data,
  output logic                empty
);
  import enfa_pkg::*;

  qent_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: sv/enfa_back.sv
// Back end: holds the move and lambda tables, runs closure and move steps, drives results.
// Depends on enfa_pkg, enfa_out_if and enfa_ram.
`default_nettype none
module enfa_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire enfa_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire enfa_pkg::qent_t q_entry,
  output logic                 q_pop,
  enfa_out_if.source           out_ch,
  output enfa_pkg::bk_stat_t   stat
);
  import enfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CLOSE  = 4'b0010,
    S_MOVE   = 4'b0100,
    S_CLOSE2 = 4'b1000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [NUM_STATES-1:0][SET_W-1:0]   lambda_r, lambda_nxt;
  logic [MV_DEPTH-1:0]                mv_vld_r, mv_vld_nxt;
  logic [SET_W-1:0]                   set_r, set_nxt;
  logic [SET_W-1:0]                   rem_r, rem_nxt;
  logic [SET_W-1:0]                   acc_r, acc_nxt;
  logic                               pend_r, pend_nxt;
  logic                               pend_ok_r, pend_ok_nxt;
  logic                               last_r, last_nxt;
  logic                               found_r, found_nxt;
  logic [SYM_W-1:0]                   sym_r, sym_nxt;
  logic                               at_start_r, at_start_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_acc_r, out_acc_nxt;
  logic [SET_W-1:0]                   out_set_r, out_set_nxt;

  logic [SET_W-1:0]     grown;
  logic [SET_W-1:0]     lo_oh;
  logic [STATE_W-1:0]   lo_idx;
  logic                 ram_we;
  logic [MV_ADDR_W-1:0] ram_waddr;
  logic [MV_ADDR_W-1:0] ram_raddr;
  logic [SET_W-1:0]     ram_rdata;
  logic                 out_free;

  // Move table storage
  enfa_ram #(
    .WIDTH (SET_W),
    .DEPTH (MV_DEPTH)
  ) u_move_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_entry.targets),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One lambda round: add the rows of every active state
  always_comb begin
    grown = set_r;
    for (int s = 0; s < NUM_STATES; s++) begin
      if (set_r[s]) begin
        grown = grown | lambda_r[s];
      end
    end
    grown = grown & STATE_MASK;
  end

  // Pick the lowest remaining state for the move walk
  always_comb begin
    lo_oh  = rem_r & SET_W'(~rem_r + 1'b1);
    lo_idx = '0;
    for (int s = NUM_STATES - 1; s >= 0; s--) begin
      if (rem_r[s]) begin
        lo_idx = STATE_W'(s);
      end
    end
  end

  assign ram_waddr = {q_entry.src, q_entry.sym};
  assign ram_raddr = {lo_idx, sym_r};
  assign out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.accepted  = out_acc_r;
  assign out_ch.final_set = out_set_r;
  assign stat.busy        = (state_r != S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    lambda_nxt    = lambda_r;
    mv_vld_nxt    = mv_vld_r;
    set_nxt       = set_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    pend_ok_nxt   = pend_ok_r;
    last_nxt      = last_r;
    found_nxt     = found_r;
    sym_nxt       = sym_r;
    at_start_nxt  = at_start_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_acc_nxt   = out_acc_r;
    out_set_nxt   = out_set_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_entry.func)
            FUNC_MOVE_ROW: begin
              ram_we                = 1'b1;
              mv_vld_nxt[ram_waddr] = 1'b1;
            end
            FUNC_LAMBDA_ROW: begin
              lambda_nxt[q_entry.src] = q_entry.targets;
            end
            FUNC_FEED: begin
              if (at_start_r) begin
                set_nxt = SET_W'(1) << cfg.start_state;
              end
              at_start_nxt = 1'b0;
              last_nxt     = q_entry.last;
              found_nxt    = q_entry.found;
              sym_nxt      = q_entry.sym;
              state_nxt    = S_CLOSE;
            end
            FUNC_ALPHA: begin
              // handled in the front; drop
            end
          endcase
        end
      end

      S_CLOSE: begin
        priority if (grown != set_r) begin
          set_nxt = grown;
        end else if (found_r) begin
          rem_nxt   = set_r;
          acc_nxt   = '0;
          state_nxt = S_MOVE;
        end else begin
          // unknown character empties the set
          set_nxt   = '0;
          state_nxt = last_r ? S_CLOSE2 : S_IDLE;
        end
      end

      S_MOVE: begin
        if (rem_r != '0) begin
          rem_nxt     = rem_r & ~lo_oh;
          pend_nxt    = 1'b1;
          pend_ok_nxt = mv_vld_r[ram_raddr];
        end
        if (pend_r && pend_ok_r) begin
          acc_nxt = acc_r | ram_rdata;
        end
        if ((rem_r == '0) && !pend_r) begin
          set_nxt   = acc_r & STATE_MASK;
          state_nxt = last_r ? S_CLOSE2 : S_IDLE;
        end
      end

      S_CLOSE2: begin
        priority if (grown != set_r) begin
          set_nxt = grown;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = |(set_r & cfg.accept_mask);
          out_set_nxt   = set_r;
          at_start_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // hold until the result slot frees
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lambda_r    <= '0;
      mv_vld_r    <= '0;
      set_r       <= '0;
      pend_r      <= 1'b0;
      at_start_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lambda_r    <= lambda_nxt;
      mv_vld_r    <= mv_vld_nxt;
      set_r       <= set_nxt;
      pend_r      <= pend_nxt;
      at_start_r  <= at_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    acc_r     <= acc_nxt;
    pend_ok_r <= pend_ok_nxt;
    last_r    <= last_nxt;
    found_r   <= found_nxt;
    sym_r     <= sym_nxt;
    out_acc_r <= out_acc_nxt;
    out_set_r <= out_set_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/epsilon_nfa_word_acceptor.sv
// Top level of the lambda-NFA word acceptor: configuration registers and module wiring.
// Depends on enfa_pkg, enfa_ifs, enfa_front, enfa_queue and enfa_back.
`default_nettype none
// Feeds words one character at a time through a 16-state automaton with lambda moves.
// Alphabet writes are taken in the front and never reach the back; transition and
// lambda row writes are applied by the back one per cycle while the back is idle.
// For a fed character the back runs lambda rounds until the set stops growing (at
// most 15 rounds grow it), then reads the move table RAM once for each active state;
// a character outside the alphabet skips the move walk and empties the set. The last
// character of a word adds a final closure, plus any wait for the result register
// to free. A two-entry queue lets the front keep accepting while the back works,
// and the result register lets the next word start while a result waits to be taken.
// All tables read as empty after reset with no clearing pass.
module epsilon_nfa_word_acceptor (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  enfa_in_if.sink                             in_ch,
  enfa_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [enfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [enfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import enfa_pkg::*;

  cfg_t     cfg_r;
  logic     q_push;
  qent_t    q_push_data;
  logic     q_full;
  logic     q_pop;
  qent_t    q_pop_data;
  logic     q_empty;
  bk_stat_t bk_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_state <= '0;
      cfg_r.accept_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_START: cfg_r.start_state <= cfg_wdata[STATE_W-1:0];
        CFG_IDX_MASK:  cfg_r.accept_mask <= cfg_wdata[SET_W-1:0];
        default: ;
      endcase
    end
  end

  enfa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_push  (q_push),
    .q_entry (q_push_data),
    .q_full  (q_full)
  );

  enfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  enfa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (!q_empty),
    .q_entry (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (bk_stat)
  );

`ifndef SYNTHESIS
  // The back never takes an item from an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // The back takes no new item while it is still working on one
  a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |-> !q_pop)
    else $error("queue popped while back busy");

  // A result only appears at the end of a busy stretch of the back
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(bk_stat.busy))
    else $error("result raised without back activity");
`endif

endmodule
`default_nettype wire
